// ===== rtl/core/somf_pkg.sv =====
// ----------------------------------------------------------------------------
// somf_pkg: shared types, constants and helpers for the motion follower
// Payload structs, register map, sequencer states and fixed-point saturation.
// ----------------------------------------------------------------------------
package somf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DT_FRAC    = 16;
    localparam int DATA_W     = 32;
    localparam int DT_W       = 16;
    localparam int GAIN_W     = 24;
    localparam int AXES       = 3;
    localparam int AX_W       = 2;
    localparam int APB_W      = 32;
    localparam int CFG_ADDR_W = 4;

    localparam int MUL_A_W    = DATA_W + 1;
    localparam int DIGIT_W    = 4;
    localparam int MUL_DIGITS = 9;
    localparam int MUL_B_W    = DIGIT_W * MUL_DIGITS;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int PP_W       = MUL_A_W + DIGIT_W + 1;
    localparam int ACC_W      = PP_W + 2;
    localparam int CNT_W      = 4;
    localparam int SUM_W      = DATA_W + 2;

    typedef struct packed {
        logic                     req_type;
        logic [DT_W-1:0]          time_step;
        logic signed [DATA_W-1:0] target_x;
        logic signed [DATA_W-1:0] target_y;
        logic signed [DATA_W-1:0] target_z;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] follow_x;
        logic signed [DATA_W-1:0] follow_y;
        logic signed [DATA_W-1:0] follow_z;
    } res_t;

    typedef struct packed {
        logic [GAIN_W-1:0]        damping_gain;
        logic [DATA_W-1:0]        stiffness_gain;
        logic signed [GAIN_W-1:0] anticipation_gain;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

    typedef enum logic [1:0] {
        CFG_DAMPING      = 2'd0,
        CFG_STIFFNESS    = 2'd1,
        CFG_ANTICIPATION = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_STEP,
        ST_POS,
        ST_MUL_K1V,
        ST_ERR,
        ST_MUL_DERR,
        ST_MUL_ANT,
        ST_INNER,
        ST_MUL_DV,
        ST_VEL,
        ST_DONE
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] a);
        logic signed [DATA_W-1:0] r;
        if (a[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){a[PROD_W-1]}})
        begin
            r = a[DATA_W-1:0];
        end
        else if (a[PROD_W-1])
        begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    // round to nearest, ties up, then clamp
    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] p,
        input int                       s
    );
        logic signed [PROD_W-1:0] q;
        q = (p >>> s) + $signed({{(PROD_W-1){1'b0}}, p[s-1]});
        return sat32(q);
    endfunction

endpackage

// ===== rtl/core/second_order_motion_follower.sv =====
// ----------------------------------------------------------------------------
// second_order_motion_follower: 3-D second-order follower, semi-implicit Euler
// Integrate: each axis takes five 9-digit passes of the shared serial multiplier.
// One transaction in flight; the next is taken once the result has moved into
//   the output register.
// Reset: gains return to k1 = 1.0, 1/k2 = 1.0, k3 = 0; position, velocity and
//   previous-target state clears.
// ----------------------------------------------------------------------------
module second_order_motion_follower (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  somf_pkg::req_t                  req,
    output logic                            res_valid,
    input  logic                            res_stall,
    output somf_pkg::res_t                  res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [somf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [somf_pkg::APB_W-1:0]      pwdata,
    output logic [somf_pkg::APB_W-1:0]      prdata,
    output logic                            pready
);
    import somf_pkg::*;

    cfg_t       cfg;
    core_stat_t stat;
    res_t       core_res;
    logic       core_start;
    logic       core_take;
    logic       res_valid_reg;
    res_t       res_reg;

    somf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    somf_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .start  (core_start),
        .req    (req),
        .take   (core_take),
        .stat   (stat),
        .result (core_res)
    );

    assign req_stall  = !stat.idle;
    assign core_start = req_valid && stat.idle;
    assign core_take  = stat.done && (!res_valid_reg || !res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (core_take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_take)
        begin
            res_reg <= core_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> !stat.idle)
        else $error("core idle after accepting a transaction");

    a_stat_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.idle && stat.done))
        else $error("core reports idle and done together");

    a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done && !res_valid |=> res_valid)
        else $error("finished result not moved to output register");

endmodule

// ===== rtl/core/somf_serial_mult.sv =====
// ----------------------------------------------------------------------------
// somf_serial_mult: digit-serial signed multiplier
// Consumes the multiplier four bits per cycle, top digit signed; the product
// accumulates high half in place and shifts low digits out into a register.
// ----------------------------------------------------------------------------
module somf_serial_mult (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [somf_pkg::MUL_A_W-1:0] a,
    input  logic [somf_pkg::MUL_B_W-1:0]        b,
    output logic                                done,
    output logic signed [somf_pkg::PROD_W-1:0]  prod
);
    import somf_pkg::*;

    logic signed [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0]        b_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [MUL_B_W-1:0]        low_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic                      last;
    logic signed [DIGIT_W:0]   digit;
    logic signed [PP_W-1:0]    pp;
    logic signed [ACC_W-1:0]   sum;
    logic signed [ACC_W-1:0]   acc_next;
    logic [MUL_B_W-1:0]        low_next;

    always_comb
    begin
        last     = (cnt_reg == CNT_W'(MUL_DIGITS - 1));
        digit    = last ? $signed({b_reg[DIGIT_W-1], b_reg[DIGIT_W-1:0]})
                        : $signed({1'b0, b_reg[DIGIT_W-1:0]});
        pp       = a_reg * digit;
        sum      = acc_reg + ACC_W'(pp);
        acc_next = sum >>> DIGIT_W;
        low_next = {sum[DIGIT_W-1:0], low_reg[MUL_B_W-1:DIGIT_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg + CNT_W'(1);
            busy_reg <= !last;
            done_reg <= last;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
            low_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= b_reg >> DIGIT_W;
            acc_reg <= acc_next;
            low_reg <= low_next;
        end
    end

    assign done = done_reg;
    assign prod = {acc_reg[MUL_A_W-1:0], low_reg};

endmodule

// ===== rtl/core/somf_regs.sv =====
// ----------------------------------------------------------------------------
// somf_regs: APB configuration registers
// Holds damping, stiffness and anticipation gains; zero-wait reads and writes.
// ----------------------------------------------------------------------------
module somf_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [somf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [somf_pkg::APB_W-1:0]        pwdata,
    output logic [somf_pkg::APB_W-1:0]        prdata,
    output logic                              pready,
    output somf_pkg::cfg_t                    cfg
);
    import somf_pkg::*;

    cfg_t     cfg_reg;
    cfg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.damping_gain      <= GAIN_W'(64'd1 << FRAC_BITS);
            cfg_reg.stiffness_gain    <= DATA_W'(64'd1 << FRAC_BITS);
            cfg_reg.anticipation_gain <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                CFG_DAMPING:      cfg_reg.damping_gain      <= pwdata[GAIN_W-1:0];
                CFG_STIFFNESS:    cfg_reg.stiffness_gain    <= pwdata[DATA_W-1:0];
                CFG_ANTICIPATION: cfg_reg.anticipation_gain <= pwdata[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            CFG_DAMPING:      prdata = APB_W'(cfg_reg.damping_gain);
            CFG_STIFFNESS:    prdata = APB_W'(cfg_reg.stiffness_gain);
            CFG_ANTICIPATION: prdata = APB_W'(unsigned'(cfg_reg.anticipation_gain));
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/somf_core.sv =====
// ----------------------------------------------------------------------------
// somf_core: per-axis update sequencer
// Walks each axis through five serial multiplies and four add/clamp steps;
// axis state sits in three-deep rings read at the head and rotated per axis.
// ----------------------------------------------------------------------------
module somf_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  somf_pkg::cfg_t        cfg,
    input  logic                  start,
    input  somf_pkg::req_t        req,
    input  logic                  take,
    output somf_pkg::core_stat_t  stat,
    output somf_pkg::res_t        result
);
    import somf_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;
    logic [AX_W-1:0]          ax_cnt_reg;
    logic                     mul_issued_reg;

    logic signed [DATA_W-1:0] pos_ring_reg  [AXES];
    logic signed [DATA_W-1:0] vel_ring_reg  [AXES];
    logic signed [DATA_W-1:0] prev_ring_reg [AXES];
    logic signed [DATA_W-1:0] xin_ring_reg  [AXES];

    logic [DT_W-1:0]          dt_reg;
    logic signed [DATA_W-1:0] step_reg;
    logic signed [DATA_W-1:0] y_reg;
    logic signed [DATA_W-1:0] k1v_reg;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] dterm_reg;
    logic signed [DATA_W-1:0] aterm_reg;
    logic signed [DATA_W-1:0] inner_reg;
    logic signed [DATA_W-1:0] dv_reg;

    logic                      is_mul;
    logic                      mul_start;
    logic                      mul_done;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [DATA_W-1:0]  rs_dt;
    logic signed [DATA_W-1:0]  rs_f;

    logic signed [SUM_W-1:0]   y_sum;
    logic signed [SUM_W-1:0]   err_sum;
    logic signed [SUM_W-1:0]   inner_sum;
    logic signed [SUM_W-1:0]   vel_sum;
    logic signed [DATA_W-1:0]  vel_new;

    somf_serial_mult u_mult (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    always_comb
    begin
        rs_dt     = round_sat(prod, DT_FRAC);
        rs_f      = round_sat(prod, FRAC_BITS);
        y_sum     = SUM_W'(pos_ring_reg[0]) + SUM_W'(step_reg);
        err_sum   = SUM_W'(xin_ring_reg[0]) - SUM_W'(y_reg) - SUM_W'(k1v_reg);
        inner_sum = SUM_W'(dterm_reg) + SUM_W'(aterm_reg);
        vel_sum   = SUM_W'(vel_ring_reg[0]) + SUM_W'(dv_reg);
        vel_new   = sat32(PROD_W'(vel_sum));
    end

    always_comb
    begin
        case (state_reg)
            ST_MUL_STEP:
            begin
                mul_a = MUL_A_W'(vel_ring_reg[0]);
                mul_b = MUL_B_W'(dt_reg);
            end
            ST_MUL_K1V:
            begin
                mul_a = MUL_A_W'(vel_ring_reg[0]);
                mul_b = MUL_B_W'(cfg.damping_gain);
            end
            ST_MUL_DERR:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(dt_reg);
            end
            ST_MUL_ANT:
            begin
                mul_a = MUL_A_W'(xin_ring_reg[0]) - MUL_A_W'(prev_ring_reg[0]);
                mul_b = MUL_B_W'(cfg.anticipation_gain);
            end
            ST_MUL_DV:
            begin
                mul_a = MUL_A_W'(inner_reg);
                mul_b = MUL_B_W'(cfg.stiffness_gain);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = req.req_type ? ST_DONE : ST_MUL_STEP;
                end
            end
            ST_MUL_STEP: if (mul_done) state_next = ST_POS;
            ST_POS:      state_next = ST_MUL_K1V;
            ST_MUL_K1V:  if (mul_done) state_next = ST_ERR;
            ST_ERR:      state_next = ST_MUL_DERR;
            ST_MUL_DERR: if (mul_done) state_next = ST_MUL_ANT;
            ST_MUL_ANT:  if (mul_done) state_next = ST_INNER;
            ST_INNER:    state_next = ST_MUL_DV;
            ST_MUL_DV:   if (mul_done) state_next = ST_VEL;
            ST_VEL:
            begin
                state_next = (ax_cnt_reg == AX_W'(AXES - 1)) ? ST_DONE : ST_MUL_STEP;
            end
            ST_DONE:     if (take) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_MUL_STEP, ST_MUL_K1V, ST_MUL_DERR, ST_MUL_ANT, ST_MUL_DV: is_mul = 1'b1;
            default:                                                     is_mul = 1'b0;
        endcase
        mul_start = is_mul && !mul_issued_reg;
        stat.idle = (state_reg == ST_IDLE);
        stat.done = (state_reg == ST_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ax_cnt_reg     <= '0;
            mul_issued_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mul_start)
            begin
                mul_issued_reg <= 1'b1;
            end
            else if (mul_done)
            begin
                mul_issued_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE)
            begin
                ax_cnt_reg <= '0;
            end
            else if (state_reg == ST_VEL)
            begin
                ax_cnt_reg <= ax_cnt_reg + AX_W'(1);
            end
        end
    end

    // axis state rings: head is the axis in work, rotate after each axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                pos_ring_reg[i]  <= '0;
                vel_ring_reg[i]  <= '0;
                prev_ring_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_IDLE && start && req.req_type)
        begin
            pos_ring_reg[0]  <= req.target_x;
            pos_ring_reg[1]  <= req.target_y;
            pos_ring_reg[2]  <= req.target_z;
            prev_ring_reg[0] <= req.target_x;
            prev_ring_reg[1] <= req.target_y;
            prev_ring_reg[2] <= req.target_z;
            for (int i = 0; i < AXES; i++)
            begin
                vel_ring_reg[i] <= '0;
            end
        end
        else if (state_reg == ST_VEL)
        begin
            for (int i = 0; i < AXES - 1; i++)
            begin
                pos_ring_reg[i]  <= pos_ring_reg[i+1];
                vel_ring_reg[i]  <= vel_ring_reg[i+1];
                prev_ring_reg[i] <= prev_ring_reg[i+1];
            end
            pos_ring_reg[AXES-1]  <= y_reg;
            vel_ring_reg[AXES-1]  <= vel_new;
            prev_ring_reg[AXES-1] <= xin_ring_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            dt_reg          <= req.time_step;
            xin_ring_reg[0] <= req.target_x;
            xin_ring_reg[1] <= req.target_y;
            xin_ring_reg[2] <= req.target_z;
        end
        else if (state_reg == ST_VEL)
        begin
            for (int i = 0; i < AXES - 1; i++)
            begin
                xin_ring_reg[i] <= xin_ring_reg[i+1];
            end
            xin_ring_reg[AXES-1] <= xin_ring_reg[0];
        end

        case (state_reg)
            ST_MUL_STEP: if (mul_done) step_reg  <= rs_dt;
            ST_POS:      y_reg     <= sat32(PROD_W'(y_sum));
            ST_MUL_K1V:  if (mul_done) k1v_reg   <= rs_f;
            ST_ERR:      err_reg   <= sat32(PROD_W'(err_sum));
            ST_MUL_DERR: if (mul_done) dterm_reg <= rs_dt;
            ST_MUL_ANT:  if (mul_done) aterm_reg <= rs_f;
            ST_INNER:    inner_reg <= sat32(PROD_W'(inner_sum));
            ST_MUL_DV:   if (mul_done) dv_reg    <= rs_f;
            default:     ;
        endcase
    end

    assign result.follow_x = pos_ring_reg[0];
    assign result.follow_y = pos_ring_reg[1];
    assign result.follow_z = pos_ring_reg[2];

endmodule
